[src/r30rg_pkg.sv]
// Shared constants for the rule 30 row generator: register indexes,
// reset values and stream widths. No dependencies.
package r30rg_pkg;

  localparam int ROW_WIDTH_DEF = 61;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FIRE_PERIOD = 2'd0,
    REG_GEN_LIMIT   = 2'd1,
    REG_RULE_NUMBER = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] FIRE_PERIOD_RST = 8'd14;
  localparam logic [5:0] GEN_LIMIT_RST   = 6'd44;
  localparam logic [7:0] RULE_NUMBER_RST = 8'd30;

  localparam int GEN_W    = 6;
  localparam int PHASE_W  = 8;
  localparam int OFFSET_W = 6;
  localparam int COLOUR_W = 4;
  localparam int SPEED_W  = 2;
  localparam logic [COLOUR_W-1:0] COLOUR_MAX = 4'd8;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 16;

endpackage

[src/rule30_row_generator.sv]
// Rule 30 row generator top level: tick sequencer, serial cell scan and
// generation step. Depends on r30rg_pkg.
// A non-firing tick is taken in IDLE and the block stays there. A firing tick
// moves through SCAN, where the single-bit scan shifter steps over the cells
// up to the highest live cell, and STEP, then back to IDLE; the shifter waits
// on a live cell while the output side stalls; s_tready is high only between ticks.
// Reset (rst, synchronous): row holds only the centre cell, generation and
// phase are zero, registers take their reset values, no result pending.
module rule30_row_generator
  import r30rg_pkg::*;
#(
  parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // tick requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
  // cell results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [5:0] cell_offset, [7:6] speed_class,
                                           // [11:8] colour_index, [15:12] zero
  output logic                  m_tlast    // last
);

  localparam int IDX_W  = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam int CENTRE = (ROW_WIDTH - 1) / 2;
  localparam logic [ROW_WIDTH-1:0] CENTRE_ROW = ROW_WIDTH'(1) << CENTRE;
  localparam logic [IDX_W:0] CENTRE_IDX = (IDX_W + 1)'(CENTRE);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    STEP
  } state_t;

  state_t                 state;
  logic [7:0]             fire_period;
  logic [GEN_W-1:0]       gen_limit;
  logic [7:0]             rule_number;
  logic [ROW_WIDTH-1:0]   cell_row;
  logic [ROW_WIDTH-1:0]   scan;
  logic [IDX_W-1:0]       idx;
  logic [GEN_W-1:0]       generation;
  logic [COLOUR_W-1:0]    colour;
  logic [PHASE_W-1:0]     tick_phase;

  // tick acceptance with restart applied first
  logic                   tick_acc;
  logic                   restart;
  logic [ROW_WIDTH-1:0]   row_eff;
  logic [GEN_W-1:0]       gen_eff;
  logic [COLOUR_W-1:0]    colour_eff;
  logic [PHASE_W-1:0]     phase_eff;
  logic [PHASE_W-1:0]     period;
  logic [PHASE_W:0]       phase_inc;
  logic [PHASE_W-1:0]     phase_next;

  // scan and step
  logic                   out_free;
  logic                   scan_adv;
  logic                   emit;
  logic                   last_cell;
  logic [IDX_W:0]         idx_ext;
  logic [OFFSET_W-1:0]    offset;
  logic [ROW_WIDTH+1:0]   padded;
  logic [ROW_WIDTH-1:0]   row_next;
  logic [GEN_W-1:0]       gen_inc;
  logic [COLOUR_W-1:0]    colour_inc;

  assign s_tready   = (state == IDLE);
  assign tick_acc   = s_tvalid && s_tready;
  assign restart    = s_tdata[0];
  assign row_eff    = restart ? CENTRE_ROW : cell_row;
  assign gen_eff    = restart ? '0 : generation;
  assign colour_eff = restart ? '0 : colour;
  assign phase_eff  = restart ? '0 : tick_phase;

  // a period of zero behaves as one
  assign period     = (fire_period == '0) ? PHASE_W'(1) : fire_period;
  assign phase_inc  = {1'b0, phase_eff} + (PHASE_W + 1)'(1);
  assign phase_next = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[PHASE_W-1:0];

  assign out_free  = !m_tvalid || m_tready;
  assign scan_adv  = (state == SCAN) && (scan != '0) && (!scan[0] || out_free);
  assign emit      = scan_adv && scan[0];
  assign last_cell = (scan >> 1) == '0;
  assign idx_ext   = {1'b0, idx};
  assign offset    = OFFSET_W'(idx_ext - CENTRE_IDX);

  // one generation step; cells beyond the edges read as zero
  assign padded = {1'b0, cell_row, 1'b0};
  always_comb begin
    for (int i = 0; i < ROW_WIDTH; i++) begin
      row_next[i] = rule_number[{padded[i], padded[i+1], padded[i+2]}];
    end
  end

  assign gen_inc    = generation + GEN_W'(1);
  assign colour_inc = (colour == COLOUR_MAX) ? '0 : colour + COLOUR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      fire_period <= FIRE_PERIOD_RST;
      gen_limit   <= GEN_LIMIT_RST;
      rule_number <= RULE_NUMBER_RST;
      cell_row    <= CENTRE_ROW;
      generation  <= '0;
      colour      <= '0;
      tick_phase  <= '0;
      scan        <= '0;
      idx         <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FIRE_PERIOD: fire_period <= cfg_wdata;
          REG_GEN_LIMIT:   gen_limit   <= cfg_wdata[GEN_W-1:0];
          REG_RULE_NUMBER: rule_number <= cfg_wdata;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (tick_acc) begin
            cell_row   <= row_eff;
            generation <= gen_eff;
            colour     <= colour_eff;
            tick_phase <= phase_next;
            if (phase_eff == '0) begin
              scan  <= row_eff;
              idx   <= '0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (scan == '0) begin
            state <= STEP;
          end else if (scan_adv) begin
            if (scan[0]) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {4'b0, colour, generation[SPEED_W-1:0], offset};
              m_tlast  <= last_cell;
            end
            scan <= scan >> 1;
            idx  <= idx + IDX_W'(1);
          end
        end
        STEP: begin
          if (gen_inc >= gen_limit) begin
            cell_row   <= CENTRE_ROW;
            generation <= '0;
            colour     <= '0;
          end else begin
            cell_row   <= row_next;
            generation <= gen_inc;
            colour     <= colour_inc;
          end
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // an emptied scan register always hands over to the generation step
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN && scan == '0) |=> (state == STEP))
    else $error("scan finished without generation step");

  // the generation is zero or below the limit after a step
  a_gen_bound: assert property (@(posedge clk) disable iff (rst)
    (state == STEP) |=> (generation == '0 || generation < gen_limit))
    else $error("generation passed its limit");

  // colour index never exceeds COLOUR_MAX; the counter tracks generation modulo nine
  a_colour_range: assert property (@(posedge clk) disable iff (rst)
    colour <= COLOUR_MAX)
    else $error("colour index out of range");

  // a pending result is never overwritten by the scan
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && state == SCAN) |=> !$changed(m_tdata))
    else $error("pending result overwritten");

endmodule
